@@ sv/r2fft_pkg.sv @@
package r2fft_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WORK_BITS       = 22;
    localparam int TW_BITS         = 16;
    localparam int ROM_LOG2        = 6;
    localparam int FRAC_BITS       = 15;
    localparam int CFG_IDX_BITS    = 8;
    localparam int CFG_DATA_BITS   = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_LOG2 = 8'd1;

    localparam logic signed [WORK_BITS-1:0] WORK_MAX = 22'sd2097151;
    localparam logic signed [WORK_BITS-1:0] WORK_MIN = -22'sd2097152;

    typedef logic signed [WORK_BITS-1:0] work_t;

    // Frame handed from the load side to the engine
    typedef struct packed {
        logic       dir;
        logic [2:0] lg;
        logic       bank;
    } job_t;

    function automatic logic [TW_BITS-1:0] quarter_cos(input logic [4:0] k);
        logic [TW_BITS-1:0] v;
        case (k)
            5'd0:  v = 16'd32767;
            5'd1:  v = 16'd32610;
            5'd2:  v = 16'd32138;
            5'd3:  v = 16'd31357;
            5'd4:  v = 16'd30274;
            5'd5:  v = 16'd28899;
            5'd6:  v = 16'd27246;
            5'd7:  v = 16'd25330;
            5'd8:  v = 16'd23170;
            5'd9:  v = 16'd20788;
            5'd10: v = 16'd18205;
            5'd11: v = 16'd15447;
            5'd12: v = 16'd12540;
            5'd13: v = 16'd9512;
            5'd14: v = 16'd6393;
            5'd15: v = 16'd3212;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic work_t sat_work(input logic signed [WORK_BITS+1:0] v);
        work_t r;
        if (v > 24'(signed'(WORK_MAX)))
            r = WORK_MAX;
        else if (v < 24'(signed'(WORK_MIN)))
            r = WORK_MIN;
        else
            r = v[WORK_BITS-1:0];
        return r;
    endfunction

endpackage

@@ sv/r2fft_front.sv @@
module r2fft_front
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int AW = $clog2(MAX_POINTS),
    localparam int FLOOR_LOG2 = $clog2(MAX_POINTS + 1) - 1,
    localparam int LIM = (FLOOR_LOG2 > ROM_LOG2) ? ROM_LOG2 : FLOOR_LOG2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic signed [SAMPLE_BITS-1:0] sample_real,
    input  logic signed [SAMPLE_BITS-1:0] sample_imag,
    input  logic                          dir,
    input  logic [2:0]                    size_cfg,
    input  logic                          size_wr,
    input  logic                          bank_free,
    output logic                          full,
    output logic                          wr_en,
    output logic                          wr_bank,
    output logic [AW-1:0]                 wr_addr,
    output work_t                         wr_re,
    output work_t                         wr_im,
    output logic                          job_valid,
    output job_t                          job
);

    logic [AW:0]   count_reg, count_next;
    logic          bank_reg;
    logic [2:0]    lg;
    logic [AW:0]   n;
    logic [AW:0]   idx;
    logic [AW-1:0] rev;

    function automatic work_t align(input logic signed [SAMPLE_BITS-1:0] s);
        logic signed [SAMPLE_BITS+WORK_BITS:0] v;
        v = (SAMPLE_BITS+WORK_BITS+1)'(s);
        if (SAMPLE_BITS > 16)
            v = (v + ((SAMPLE_BITS+WORK_BITS+1)'(1) <<< (SAMPLE_BITS-17)))
                >>> (SAMPLE_BITS-16);
        else
            v = v <<< (16-SAMPLE_BITS);
        return v[WORK_BITS-1:0];
    endfunction

    always_comb
    begin
        lg = size_cfg;
        if (lg < 3'd1)
            lg = 3'd1;
        if (lg > 3'(LIM))
            lg = 3'(LIM);
        n   = (AW+1)'(1) << lg;
        idx = (count_reg >= n) ? '0 : count_reg;
        count_next = idx + 1'b1;
    end

    // Samples land at their bit-reversed position
    always_comb
    begin
        rev = '0;
        for (int b = 0; b < AW; b++)
            if (b < int'(lg))
                rev[int'(lg) - 1 - b] = idx[b];
    end

    assign full      = !bank_free;
    assign wr_en     = take;
    assign wr_bank   = bank_reg;
    assign wr_addr   = rev;
    assign wr_re     = align(sample_real);
    assign wr_im     = align(sample_imag);
    assign job_valid = take && (count_next == n);
    assign job       = '{dir: dir, lg: lg, bank: bank_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else if (size_wr)
            count_reg <= '0;
        else if (take)
        begin
            if (job_valid)
            begin
                count_reg <= '0;
                bank_reg  <= !bank_reg;
            end
            else
                count_reg <= count_next;
        end
    end

endmodule

@@ sv/r2fft_queue.sv @@
module r2fft_queue
    import r2fft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic has_job,
    output job_t head,
    output logic bank_free
);

    job_t       slot_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wp_reg;

    assign has_job   = cnt_reg != 2'd0;
    assign head      = slot_reg[rd_reg];
    assign bank_free = cnt_reg != 2'd2;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ sv/r2fft_engine.sv @@
module r2fft_engine
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int AW = $clog2(MAX_POINTS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic          wr_bank,
    input  logic [AW-1:0] wr_addr,
    input  work_t         wr_re,
    input  work_t         wr_im,
    input  logic          has_job,
    input  job_t          job,
    output logic          pop,
    output work_t         bin_real,
    output work_t         bin_imag,
    output logic          bin_last,
    output logic          strobe
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RB   = 9'b000000010,
        S_RA   = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_RND  = 9'b000010000,
        S_WA   = 9'b000100000,
        S_WB   = 9'b001000000,
        S_OUTR = 9'b010000000,
        S_OUTW = 9'b100000000
    } state_t;

    localparam int MW = WORK_BITS + TW_BITS + 1;

    work_t mem_re [2**(AW+1)];
    work_t mem_im [2**(AW+1)];

    state_t       state_reg;
    logic [2:0]   stage_reg;
    logic [AW-1:0] j_reg, i_reg, k_reg;
    logic [AW:0]  n;
    logic [AW-1:0] half;
    logic [AW-1:0] p;
    logic         bank;
    logic         rd_en;
    logic [AW:0]  rd_addr;
    work_t        rd_re_reg, rd_im_reg;
    work_t        ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [TW_BITS:0] wr_reg, wi_reg;
    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [WORK_BITS+1:0] tr_reg, ti_reg;
    logic         we;
    logic [AW:0]  we_addr;
    work_t        we_re, we_im;
    logic [4:0]   tk;
    logic signed [TW_BITS:0] tc, ts;

    assign n    = (AW+1)'(1) << job.lg;
    assign half = AW'((AW+1)'(1) << (stage_reg - 3'd1));
    assign p    = i_reg + half;
    assign bank = job.bank;

    // Twiddle index j * 2^(6-s), taken mod 32
    always_comb
    begin
        logic [11:0] kk;
        kk = 12'(j_reg) << (3'(ROM_LOG2) - stage_reg);
        tk = kk[4:0];
        if (tk <= 5'd16)
        begin
            tc = (TW_BITS+1)'(quarter_cos(tk));
            ts = (TW_BITS+1)'(quarter_cos(5'd16 - tk));
        end
        else
        begin
            tc = -(TW_BITS+1)'(quarter_cos(5'd0 - tk));
            ts = (TW_BITS+1)'(quarter_cos(tk - 5'd16));
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {bank, i_reg};
        case (state_reg)
            S_IDLE:
            begin
                rd_en = 1'b0;
            end
            S_RB:
            begin
                rd_en   = 1'b1;
                rd_addr = {bank, p};
            end
            S_RA:
            begin
                rd_en   = 1'b1;
                rd_addr = {bank, i_reg};
            end
            S_OUTR:
            begin
                rd_en   = 1'b1;
                rd_addr = {bank, k_reg};
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Loader writes the other bank and has the port; butterfly writeback waits for it
    always_comb
    begin
        logic signed [WORK_BITS+1:0] sa_r, sa_i, sb_r, sb_i;
        sa_r = 24'(ar_reg) + tr_reg;
        sa_i = 24'(ai_reg) + ti_reg;
        sb_r = 24'(ar_reg) - tr_reg;
        sb_i = 24'(ai_reg) - ti_reg;
        we = wr_en;
        we_addr = {wr_bank, wr_addr};
        we_re = wr_re;
        we_im = wr_im;
        if (wr_en)
        begin
            we_addr = {wr_bank, wr_addr};
        end
        else if (state_reg == S_WA)
        begin
            we = 1'b1;
            we_addr = {bank, i_reg};
            we_re = sat_work(sa_r);
            we_im = sat_work(sa_i);
        end
        else if (state_reg == S_WB)
        begin
            we = 1'b1;
            we_addr = {bank, p};
            we_re = sat_work(sb_r);
            we_im = sat_work(sb_i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_re[we_addr] <= we_re;
            mem_im[we_addr] <= we_im;
        end
        if (rd_en)
        begin
            rd_re_reg <= mem_re[rd_addr];
            rd_im_reg <= mem_im[rd_addr];
        end
    end

    // Frames are already bit-reversed; fetch b, fetch a, multiply, round, write back
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_RA:
            begin
                br_reg <= rd_re_reg;
                bi_reg <= rd_im_reg;
                wr_reg <= tc;
                wi_reg <= job.dir ? -ts : ts;
            end
            S_MUL:
            begin
                ar_reg <= rd_re_reg;
                ai_reg <= rd_im_reg;
                m1_reg <= MW'(wr_reg) * MW'(br_reg);
                m2_reg <= MW'(wi_reg) * MW'(bi_reg);
                m3_reg <= MW'(wr_reg) * MW'(bi_reg);
                m4_reg <= MW'(wi_reg) * MW'(br_reg);
            end
            S_RND:
            begin
                tr_reg <= 24'((m1_reg - m2_reg + MW'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
                ti_reg <= 24'((m3_reg + m4_reg + MW'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
            end
            default:
            begin
            end
        endcase
    end

    logic out_v_reg, out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            stage_reg    <= 3'd1;
            j_reg        <= '0;
            i_reg        <= '0;
            k_reg        <= '0;
            out_v_reg    <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (has_job && !pop)
                    begin
                        state_reg <= S_RB;
                        stage_reg <= 3'd1;
                        j_reg     <= '0;
                        i_reg     <= '0;
                    end
                end
                S_RB:
                    state_reg <= S_RA;
                S_RA:
                    state_reg <= S_MUL;
                S_MUL:
                    state_reg <= S_RND;
                S_RND:
                    state_reg <= S_WA;
                S_WA:
                begin
                    if (!wr_en)
                        state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (!wr_en)
                    begin
                        state_reg <= S_RB;
                        if ((AW+1)'(p) + (AW+1)'(half) < n)
                            i_reg <= p + half;
                        else if (j_reg + 1'b1 < half)
                        begin
                            j_reg <= j_reg + 1'b1;
                            i_reg <= j_reg + 1'b1;
                        end
                        else if (stage_reg < job.lg)
                        begin
                            stage_reg <= stage_reg + 3'd1;
                            j_reg     <= '0;
                            i_reg     <= '0;
                        end
                        else
                        begin
                            state_reg <= S_OUTR;
                            k_reg     <= '0;
                        end
                    end
                end
                S_OUTR:
                    state_reg <= S_OUTW;
                S_OUTW:
                begin
                    out_v_reg    <= 1'b1;
                    out_last_reg <= (AW+1)'(k_reg) == n - 1'b1;
                    k_reg        <= k_reg + 1'b1;
                    state_reg    <= ((AW+1)'(k_reg) == n - 1'b1) ? S_IDLE : S_OUTR;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    work_t o_re, o_im;
    always_comb
    begin
        logic signed [WORK_BITS+1:0] v_r, v_i;
        v_r = 24'(rd_re_reg);
        v_i = 24'(rd_im_reg);
        if (job.dir)
        begin
            v_r = (v_r + (24'(1) <<< (job.lg - 3'd1))) >>> job.lg;
            v_i = (v_i + (24'(1) <<< (job.lg - 3'd1))) >>> job.lg;
        end
        o_re = sat_work(v_r);
        o_im = sat_work(v_i);
    end

    work_t out_re_reg, out_im_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUTW)
        begin
            out_re_reg <= o_re;
            out_im_reg <= o_im;
        end
    end

    assign pop      = out_v_reg && out_last_reg;
    assign strobe   = out_v_reg;
    assign bin_real = out_re_reg;
    assign bin_imag = out_im_reg;
    assign bin_last = out_v_reg && out_last_reg;

endmodule

@@ sv/radix2_complex_fft_unit.sv @@
// Radix-2 FFT of 2..64 complex points. Samples are taken one per cycle while busy is
// low, at their bit-reversed position, into one of two frame banks; once a frame is full
// it is queued for the butterfly engine and loading continues into the other bank. The
// engine takes a queued frame once idle and, for each butterfly, fetches b, fetches a,
// multiplies, rounds and writes back a then b; each write step waits while a sample is
// being loaded. It then presents the N bins in natural order with a strobe; the receiver
// cannot stall them and must take each when strobed. With frames back to back the single
// butterfly unit sets the pace.
// busy is high only while both banks hold frames not yet delivered.
module radix2_complex_fft_unit
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] sample_real,
    input  logic signed [SAMPLE_BITS-1:0] sample_imag,
    output logic                          strobe,
    output logic signed [WORK_BITS-1:0]   bin_real,
    output logic signed [WORK_BITS-1:0]   bin_imag,
    output logic                          bin_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);

    logic          dir_reg;
    logic [2:0]    size_reg;
    logic          cfg_wr, size_wr, take;
    logic          full, wr_en, wr_bank, job_valid, has_job, pop, bank_free;
    logic [AW-1:0] wr_addr;
    work_t         wr_re, wr_im;
    job_t          job, head;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign size_wr   = cfg_wr && (cfg_index == REG_SIZE_LOG2);
    assign take      = start && !busy;
    assign busy      = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= 1'b1;
            size_reg <= 3'd6;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == REG_DIRECTION)
                dir_reg <= cfg_data[0];
            else if (cfg_index == REG_SIZE_LOG2)
                size_reg <= cfg_data[2:0];
        end
    end

    r2fft_front #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .take(take),
        .sample_real(sample_real), .sample_imag(sample_imag),
        .dir(dir_reg), .size_cfg(size_reg), .size_wr(size_wr),
        .bank_free(bank_free), .full(full),
        .wr_en(wr_en), .wr_bank(wr_bank), .wr_addr(wr_addr),
        .wr_re(wr_re), .wr_im(wr_im), .job_valid(job_valid), .job(job)
    );

    r2fft_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(job_valid), .push_job(job),
        .pop(pop), .has_job(has_job), .head(head), .bank_free(bank_free)
    );

    r2fft_engine #(.MAX_POINTS(MAX_POINTS)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_bank(wr_bank), .wr_addr(wr_addr),
        .wr_re(wr_re), .wr_im(wr_im),
        .has_job(has_job), .job(head), .pop(pop),
        .bin_real(bin_real), .bin_imag(bin_imag),
        .bin_last(bin_last), .strobe(strobe)
    );

    a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        bin_last |-> strobe) else $error("bin_last without strobe");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !wr_en) else $error("load while both banks held");
    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> has_job) else $error("frame retired with empty queue");

endmodule
